>>> sv/rv32i_core_with_vectored_irq_defines.svh
// ---------------------------------------------------------------------------
// rv32i core assertion macros
// Shared property forms for the port checker of the core.
// ---------------------------------------------------------------------------
`ifndef RV32I_CORE_WITH_VECTORED_IRQ_DEFINES_SVH
`define RV32I_CORE_WITH_VECTORED_IRQ_DEFINES_SVH

// same-cycle implication
`define RVIRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvirq check failed");

// next-cycle implication
`define RVIRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvirq check failed");

`endif

>>> sv/rvirq_pkg.sv
// ---------------------------------------------------------------------------
// rvirq_pkg
// Opcodes, function codes and shared types of the rv32i core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvirq_pkg;

    localparam int unsigned DATA_BYTES_DEF = 4096;

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_URET   = 32'h0020_0073;
    localparam logic [31:0] INS_WFI    = 32'h1050_0073;
    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    localparam logic [1:0] SZ_B = 2'd0;
    localparam logic [1:0] SZ_H = 2'd1;
    localparam logic [1:0] SZ_W = 2'd2;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_dm_req;

endpackage

>>> sv/rvirq_if.sv
// ---------------------------------------------------------------------------
// rvirq interfaces
// Instruction channel and result channel of the rv32i core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvirq_cmd_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic [31:0] irq_lines;

    modport source (output valid, output instruction, output irq_lines, input ready);
    modport sink   (input valid, input instruction, input irq_lines, output ready);
endinterface

interface rvirq_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        halted;
    logic        waiting;
    logic [31:0] active_irq_mask;
    logic [63:0] run_count;
    logic [63:0] wait_count;

    modport source (output valid, output next_pc, output halted, output waiting,
                    output active_irq_mask, output run_count, output wait_count,
                    input ready);
    modport sink   (input valid, input next_pc, input halted, input waiting,
                    input active_irq_mask, input run_count, input wait_count,
                    output ready);
endinterface

>>> sv/rvirq_regfile.sv
// ---------------------------------------------------------------------------
// rvirq_regfile
// 32 x 32 register memory, two registered reads, one write, reset to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvirq_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [4:0]        i_rs1,
    input  logic [4:0]        i_rs2,
    input  rvirq_pkg::t_rf_wr i_wr,
    output logic [31:0]       o_rd1,
    output logic [31:0]       o_rd2
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_d1;
    logic [31:0] r_d2;
    logic        r_v1;
    logic        r_v2;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_d1 <= r_mem[i_rs1];
        r_d2 <= r_mem[i_rs2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_v1 <= r_vld[i_rs1];
            r_v2 <= r_vld[i_rs2];
        end
    end

    assign o_rd1 = r_v1 ? r_d1 : '0;
    assign o_rd2 = r_v2 ? r_d2 : '0;

endmodule

>>> sv/rvirq_dmem.sv
// ---------------------------------------------------------------------------
// rvirq_dmem
// Four byte banks, unaligned little-endian access, out-of-range bytes zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvirq_dmem #(
    parameter int unsigned DATA_BYTES = rvirq_pkg::DATA_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rvirq_pkg::t_dm_req i_req,
    output logic [31:0]        o_rdata
);

    localparam int unsigned ROWS = (DATA_BYTES + 3) / 4;
    localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [1:0]    w_off  [4];
    logic [31:0]   w_la   [4];
    logic [AW-1:0] w_row  [4];
    logic [7:0]    w_byte [4];
    logic [3:0]    w_keep;
    logic [1:0]    w_last;
    logic [7:0]    r_q    [4];
    logic [3:0]    r_keep;
    logic [1:0]    r_off0;

    always_comb begin
        unique case (i_req.size)
            rvirq_pkg::SZ_B: w_last = 2'd0;
            rvirq_pkg::SZ_H: w_last = 2'd1;
            default:         w_last = 2'd3;
        endcase
        for (int k = 0; k < 4; k++) begin
            w_off[k]  = 2'(k) - i_req.addr[1:0];
            w_la[k]   = i_req.addr + {30'd0, w_off[k]};
            w_row[k]  = w_la[k][AW+1:2];
            w_byte[k] = 8'(i_req.wdata >> {w_off[k], 3'b000});
            w_keep[k] = (w_off[k] <= w_last) && (w_la[k] < 32'(DATA_BYTES));
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [7:0] r_bank [ROWS];
        always_ff @(posedge i_clk) begin
            if (i_req.wr && w_keep[g]) begin
                r_bank[w_row[g]] <= w_byte[g];
            end
            if (i_req.rd) begin
                r_q[g] <= r_bank[w_row[g]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0;
            r_off0 <= '0;
        end else if (i_req.rd) begin
            r_keep <= w_keep;
            r_off0 <= i_req.addr[1:0];
        end
    end

    always_comb begin
        logic [1:0] bank;
        for (int i = 0; i < 4; i++) begin
            bank = r_off0 + 2'(i);
            o_rdata[8*i +: 8] = r_keep[bank] ? r_q[bank] : 8'd0;
        end
    end

endmodule

>>> sv/rv32i_core_with_vectored_irq.sv
// ---------------------------------------------------------------------------
// rv32i_core_with_vectored_irq
// RV32I core with vectored interrupts, one instruction word per clock while o_rsp does not stall.
// ---------------------------------------------------------------------------
//  channel | dir | word
//  i_cmd   | in  | instruction, irq_lines
//  o_rsp   | out | next_pc, halted, waiting, active_irq_mask, run/wait count
//
//  One word per clock unless o_rsp stalls; results come from the output register after execute.
//  Register reads come from a registered-read memory, bypassed from the two most
//  recent writes; loads write back in the cycle after execute.
//  Synchronous active-low reset; the register file reads zero until written.
//  A stalled o_rsp holds the word in execute and re-reads its operands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32i_core_with_vectored_irq #(
    parameter int unsigned DATA_BYTES = rvirq_pkg::DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvirq_cmd_if.sink   i_cmd,
    rvirq_rsp_if.source o_rsp
);

    logic        r_a_vld;
    logic [31:0] r_a_ins;
    logic [31:0] r_a_irq;
    logic        a_go;
    logic        in_rdy;

    logic [31:0] r_pc, n_pc;
    logic [31:0] r_ret, n_ret;
    logic [31:0] r_act, n_act;
    logic        r_halt, n_halt;
    logic        r_wfi, n_wfi;
    logic [63:0] r_run, n_run;
    logic [63:0] r_wait, n_wait;

    logic        r_out_vld;
    logic [31:0] r_out_pc;
    logic        r_out_halt;
    logic        r_out_wfi;
    logic [31:0] r_out_act;
    logic [63:0] r_out_run;
    logic [63:0] r_out_wait;

    logic        r_w_vld;
    logic        r_w_load;
    logic [4:0]  r_w_rd;
    logic [2:0]  r_w_f3;
    logic [31:0] r_w_data;
    logic        r_lw_vld;
    logic [4:0]  r_lw_addr;
    logic [31:0] r_lw_data;

    rvirq_pkg::t_rf_wr  rf_wr;
    rvirq_pkg::t_dm_req dm_req;
    logic [31:0] dm_rdata;
    logic [31:0] ld_val;
    logic [31:0] rd1, rd2;
    logic [4:0]  rs1_rd, rs2_rd;

    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] opa, opb, imm_i, imm_s, imm_b, imm_j, alu_b, alu_v;
    logic        alu_ok, take, exec, irq_take, wr_en;
    logic [31:0] wr_val;
    logic        ld_en, st_en;
    logic [1:0]  mem_size;
    logic [31:0] irq_hot;
    logic [4:0]  irq_n;

    function automatic logic [32:0] alu_op(input logic [2:0] fn3, input logic [6:0] fn7,
                                           input logic [31:0] a, input logic [31:0] b,
                                           input logic reg_form);
        logic        base;
        logic [31:0] v;
        logic        ok;
        base = !reg_form || (fn7 == rvirq_pkg::F7_BASE);
        ok   = base;
        v    = '0;
        case (fn3)
            rvirq_pkg::F3_ADD: begin
                if (reg_form && fn7 == rvirq_pkg::F7_ALT) begin
                    v  = a - b;
                    ok = 1'b1;
                end else begin
                    v = a + b;
                end
            end
            rvirq_pkg::F3_SLL:  v = a << b[4:0];
            rvirq_pkg::F3_SLT:  v = {31'd0, $signed(a) < $signed(b)};
            rvirq_pkg::F3_SLTU: v = {31'd0, a < b};
            rvirq_pkg::F3_XOR:  v = a ^ b;
            rvirq_pkg::F3_SR: begin
                ok = (fn7 == rvirq_pkg::F7_BASE) || (fn7 == rvirq_pkg::F7_ALT);
                v  = (fn7 == rvirq_pkg::F7_ALT) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            end
            rvirq_pkg::F3_OR:   v = a | b;
            default:            v = a & b;
        endcase
        return {ok, v};
    endfunction

    assign a_go   = r_a_vld && (!r_out_vld || o_rsp.ready);
    assign in_rdy = !r_a_vld || a_go;
    assign i_cmd.ready = in_rdy;

    assign rs1_rd = in_rdy ? i_cmd.instruction[19:15] : r_a_ins[19:15];
    assign rs2_rd = in_rdy ? i_cmd.instruction[24:20] : r_a_ins[24:20];

    rvirq_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rs1   (rs1_rd),
        .i_rs2   (rs2_rd),
        .i_wr    (rf_wr),
        .o_rd1   (rd1),
        .o_rd2   (rd2)
    );

    rvirq_dmem #(.DATA_BYTES(DATA_BYTES)) u_dm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dm_req),
        .o_rdata (dm_rdata)
    );

    always_comb begin
        case (r_w_f3)
            rvirq_pkg::F3_LB: ld_val = {{24{dm_rdata[7]}}, dm_rdata[7:0]};
            rvirq_pkg::F3_LH: ld_val = {{16{dm_rdata[15]}}, dm_rdata[15:0]};
            default:          ld_val = dm_rdata;
        endcase
        rf_wr.en   = r_w_vld;
        rf_wr.addr = r_w_rd;
        rf_wr.data = r_w_load ? ld_val : r_w_data;
    end

    always_comb begin
        op    = r_a_ins[6:0];
        rd    = r_a_ins[11:7];
        f3    = r_a_ins[14:12];
        f7    = r_a_ins[31:25];
        imm_i = {{20{r_a_ins[31]}}, r_a_ins[31:20]};
        imm_s = {{20{r_a_ins[31]}}, r_a_ins[31:25], r_a_ins[11:7]};
        imm_b = {{19{r_a_ins[31]}}, r_a_ins[31], r_a_ins[7], r_a_ins[30:25],
                 r_a_ins[11:8], 1'b0};
        imm_j = {{11{r_a_ins[31]}}, r_a_ins[31], r_a_ins[19:12], r_a_ins[20],
                 r_a_ins[30:21], 1'b0};

        if (rf_wr.en && rf_wr.addr == r_a_ins[19:15]) begin
            opa = rf_wr.data;
        end else if (r_lw_vld && r_lw_addr == r_a_ins[19:15]) begin
            opa = r_lw_data;
        end else begin
            opa = rd1;
        end
        if (rf_wr.en && rf_wr.addr == r_a_ins[24:20]) begin
            opb = rf_wr.data;
        end else if (r_lw_vld && r_lw_addr == r_a_ins[24:20]) begin
            opb = r_lw_data;
        end else begin
            opb = rd2;
        end

        if (op == rvirq_pkg::OP_REG) begin
            alu_b = opb;
        end else if (f3 == rvirq_pkg::F3_SLL || f3 == rvirq_pkg::F3_SR) begin
            alu_b = {27'd0, imm_i[4:0]};
        end else begin
            alu_b = imm_i;
        end
        {alu_ok, alu_v} = alu_op(f3, f7, opa, alu_b, op == rvirq_pkg::OP_REG);

        case (f3)
            rvirq_pkg::F3_BEQ:  take = (opa == opb);
            rvirq_pkg::F3_BNE:  take = (opa != opb);
            rvirq_pkg::F3_BLT:  take = ($signed(opa) < $signed(opb));
            rvirq_pkg::F3_BGE:  take = !($signed(opa) < $signed(opb));
            rvirq_pkg::F3_BLTU: take = (opa < opb);
            rvirq_pkg::F3_BGEU: take = (opa >= opb);
            default:            take = 1'b0;
        endcase

        irq_hot = r_a_irq & (~r_a_irq + 32'd1);
        irq_n   = '0;
        for (int i = 0; i < 32; i++) begin
            if (irq_hot[i]) begin
                irq_n = irq_n | 5'(i);
            end
        end

        irq_take = !r_halt && (r_a_irq != '0) && (r_act == '0);
        exec     = !r_halt && !irq_take && !r_wfi;

        n_pc   = r_pc;
        n_ret  = r_ret;
        n_act  = r_act;
        n_halt = r_halt;
        n_wfi  = r_wfi;
        n_run  = r_run;
        n_wait = r_wait;
        wr_en  = 1'b0;
        wr_val = r_pc + 32'd4;
        ld_en  = 1'b0;
        st_en  = 1'b0;
        mem_size = rvirq_pkg::SZ_B;

        if (!r_halt) begin
            if (r_wfi) begin
                n_wait = r_wait + 64'd1;
            end else begin
                n_run = r_run + 64'd1;
            end
        end

        if (irq_take) begin
            n_wfi = 1'b0;
            n_act = irq_hot;
            n_ret = r_pc;
            n_pc  = {25'd0, irq_n, 2'b00} + 32'd4;
        end else if (exec) begin
            n_pc = r_pc + 32'd4;
            unique case (op)
                rvirq_pkg::OP_REG, rvirq_pkg::OP_IMM: begin
                    wr_en  = alu_ok;
                    wr_val = alu_v;
                end
                rvirq_pkg::OP_LOAD: begin
                    case (f3) inside
                        rvirq_pkg::F3_LB, rvirq_pkg::F3_LBU: begin
                            ld_en = 1'b1;
                            mem_size = rvirq_pkg::SZ_B;
                        end
                        rvirq_pkg::F3_LH, rvirq_pkg::F3_LHU: begin
                            ld_en = 1'b1;
                            mem_size = rvirq_pkg::SZ_H;
                        end
                        rvirq_pkg::F3_LW: begin
                            ld_en = 1'b1;
                            mem_size = rvirq_pkg::SZ_W;
                        end
                        default: ld_en = 1'b0;
                    endcase
                end
                rvirq_pkg::OP_STORE: begin
                    st_en    = (f3[1:0] != 2'b11) && !f3[2];
                    mem_size = f3[1:0];
                end
                rvirq_pkg::OP_LUI: begin
                    wr_en  = 1'b1;
                    wr_val = r_a_ins & rvirq_pkg::UPPER_MASK;
                end
                rvirq_pkg::OP_AUIPC: begin
                    wr_en  = 1'b1;
                    wr_val = r_pc + (r_a_ins & rvirq_pkg::UPPER_MASK);
                end
                rvirq_pkg::OP_JAL: begin
                    wr_en = 1'b1;
                    n_pc  = r_pc + imm_j;
                end
                rvirq_pkg::OP_JALR: begin
                    wr_en = 1'b1;
                    n_pc  = (opa + imm_i) & ~32'd1;
                end
                rvirq_pkg::OP_BRANCH: begin
                    if (take) begin
                        n_pc = r_pc + imm_b;
                    end
                end
                rvirq_pkg::OP_SYSTEM: begin
                    if (r_a_ins == rvirq_pkg::INS_ECALL) begin
                        n_halt = 1'b1;
                        n_pc   = r_pc;
                    end else if (r_a_ins == rvirq_pkg::INS_URET) begin
                        n_act = '0;
                        n_pc  = r_ret;
                    end else if (r_a_ins == rvirq_pkg::INS_WFI) begin
                        n_wfi = 1'b1;
                    end
                end
                default: begin
                    n_halt = 1'b1;
                    n_pc   = r_pc;
                end
            endcase
        end

        dm_req.rd    = a_go && ld_en;
        dm_req.wr    = a_go && st_en;
        dm_req.size  = mem_size;
        dm_req.addr  = opa + (st_en ? imm_s : imm_i);
        dm_req.wdata = opb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_w_vld   <= 1'b0;
            r_lw_vld  <= 1'b0;
            r_pc      <= '0;
            r_ret     <= '0;
            r_act     <= '0;
            r_halt    <= 1'b0;
            r_wfi     <= 1'b0;
            r_run     <= '0;
            r_wait    <= '0;
        end else begin
            if (in_rdy) begin
                r_a_vld <= i_cmd.valid;
            end
            r_lw_vld <= rf_wr.en;
            r_w_vld  <= a_go && (wr_en || ld_en) && (rd != 5'd0);
            if (a_go) begin
                r_out_vld <= 1'b1;
                r_pc      <= n_pc;
                r_ret     <= n_ret;
                r_act     <= n_act;
                r_halt    <= n_halt;
                r_wfi     <= n_wfi;
                r_run     <= n_run;
                r_wait    <= n_wait;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy) begin
            r_a_ins <= i_cmd.instruction;
            r_a_irq <= i_cmd.irq_lines;
        end
        r_lw_addr <= rf_wr.addr;
        r_lw_data <= rf_wr.data;
        r_w_load  <= ld_en;
        r_w_rd    <= rd;
        r_w_f3    <= f3;
        r_w_data  <= wr_val;
        if (a_go) begin
            r_out_pc   <= n_pc;
            r_out_halt <= n_halt;
            r_out_wfi  <= n_wfi;
            r_out_act  <= n_act;
            r_out_run  <= n_run;
            r_out_wait <= n_wait;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.next_pc         = r_out_pc;
    assign o_rsp.halted          = r_out_halt;
    assign o_rsp.waiting         = r_out_wfi;
    assign o_rsp.active_irq_mask = r_out_act;
    assign o_rsp.run_count       = r_out_run;
    assign o_rsp.wait_count      = r_out_wait;

endmodule

>>> sv/rvirq_checker.sv
// ---------------------------------------------------------------------------
// rvirq_checker
// Port-level checks on the result channel of the rv32i core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rv32i_core_with_vectored_irq_defines.svh"

module rvirq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_next_pc,
    input logic        i_halted,
    input logic        i_waiting,
    input logic [31:0] i_active_irq_mask
);

    logic        r_seen;
    logic        r_halt;
    logic [31:0] r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_halt <= 1'b0;
            r_pc   <= '0;
        end else if (i_valid && i_ready) begin
            r_seen <= 1'b1;
            r_halt <= i_halted;
            r_pc   <= i_next_pc;
        end
    end

    `RVIRQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid)
    `RVIRQ_ASSERT_NOW(a_halt_no_wait, i_clk, i_rst_n, i_valid && i_halted, !i_waiting)
    `RVIRQ_ASSERT_NOW(a_irq_onehot, i_clk, i_rst_n, i_valid, $onehot0(i_active_irq_mask))
    `RVIRQ_ASSERT_NOW(a_halt_sticky, i_clk, i_rst_n, i_valid && r_seen && r_halt, i_halted && (i_next_pc == r_pc))

endmodule

bind rv32i_core_with_vectored_irq rvirq_checker u_rvirq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_rsp.valid),
    .i_ready           (o_rsp.ready),
    .i_next_pc         (o_rsp.next_pc),
    .i_halted          (o_rsp.halted),
    .i_waiting         (o_rsp.waiting),
    .i_active_irq_mask (o_rsp.active_irq_mask)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Runs directed and random RV32I instruction words with interrupt lines
// through the core and checks every result word against a local predictor.
// ---------------------------------------------------------------------------

module testbench;

    localparam int unsigned MEM_BYTES = rvirq_pkg::DATA_BYTES_DEF;
    localparam int          N_RANDOM  = 1600;

    typedef struct packed {
        logic [31:0] ins;
        logic [31:0] irq;
    } t_cmd_word;

    typedef struct packed {
        logic [31:0] pc;
        logic        halted;
        logic        waiting;
        logic [31:0] mask;
        logic [63:0] run_c;
        logic [63:0] wait_c;
    } t_core_view;

    logic i_clk;
    logic i_rst_n;

    rvirq_cmd_if cmd_bus ();
    rvirq_rsp_if rsp_bus ();

    rv32i_core_with_vectored_irq i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    t_cmd_word  pending_words[$];
    t_core_view expected_views[$];
    int         mismatches;
    int         cycle_no;
    int         hold_left;

    // predictor state
    logic [31:0] m_rf[32];
    logic [7:0]  m_mem[MEM_BYTES];
    bit          m_written[MEM_BYTES];
    logic [31:0] m_pc;
    logic [31:0] m_ret;
    logic [31:0] m_active;
    logic        m_halt;
    logic        m_wfi;
    logic [63:0] m_run;
    logic [63:0] m_wait;

    function automatic logic [32:0] alu_calc(logic [2:0] f3, logic [6:0] f7,
                                             logic [31:0] a, logic [31:0] b,
                                             bit reg_form);
        logic base_ok;
        base_ok = !reg_form || f7 == rvirq_pkg::F7_BASE;
        case (f3)
            rvirq_pkg::F3_ADD: begin
                if (base_ok) return {1'b1, a + b};
                if (f7 == rvirq_pkg::F7_ALT) return {1'b1, a - b};
            end
            rvirq_pkg::F3_SLL:  if (base_ok) return {1'b1, a << b[4:0]};
            rvirq_pkg::F3_SLT:  if (base_ok) return {1'b1, 31'd0, $signed(a) < $signed(b)};
            rvirq_pkg::F3_SLTU: if (base_ok) return {1'b1, 31'd0, a < b};
            rvirq_pkg::F3_XOR:  if (base_ok) return {1'b1, a ^ b};
            rvirq_pkg::F3_SR: begin
                if (f7 == rvirq_pkg::F7_BASE) return {1'b1, a >> b[4:0]};
                if (f7 == rvirq_pkg::F7_ALT) return {1'b1, 32'($signed(a) >>> b[4:0])};
            end
            rvirq_pkg::F3_OR:   if (base_ok) return {1'b1, a | b};
            default:            if (base_ok) return {1'b1, a & b};
        endcase
        return 33'd0;
    endfunction

    function automatic logic [31:0] mem_read(logic [31:0] addr, int n);
        logic [31:0] v;
        logic [31:0] ai;
        v = '0;
        for (int i = 0; i < n; i++) begin
            ai = addr + 32'(i);
            if (ai < MEM_BYTES) v[8*i +: 8] = m_mem[ai];
        end
        return v;
    endfunction

    task automatic mem_write(logic [31:0] addr, int n, logic [31:0] v);
        logic [31:0] ai;
        for (int i = 0; i < n; i++) begin
            ai = addr + 32'(i);
            if (ai < MEM_BYTES) begin
                m_mem[ai] = v[8*i +: 8];
                m_written[ai] = 1'b1;
            end
        end
    endtask

    task automatic reg_write(logic [4:0] rd, logic [31:0] v);
        if (rd != 5'd0) m_rf[rd] = v;
    endtask

    function automatic int load_size(logic [2:0] f3);
        case (f3)
            rvirq_pkg::F3_LB, rvirq_pkg::F3_LBU: return 1;
            rvirq_pkg::F3_LH, rvirq_pkg::F3_LHU: return 2;
            rvirq_pkg::F3_LW:                    return 4;
            default:                             return 0;
        endcase
    endfunction

    task automatic exec_word(logic [31:0] ins);
        logic [31:0] pc, nxt, a, b, imm_i, addr, v;
        logic [32:0] res;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        bit          take;
        pc = m_pc;
        nxt = pc + 32'd4;
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        a = m_rf[ins[19:15]];
        b = m_rf[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        case (ins[6:0])
            rvirq_pkg::OP_REG: begin
                res = alu_calc(f3, f7, a, b, 1'b1);
                if (res[32]) reg_write(rd, res[31:0]);
            end
            rvirq_pkg::OP_IMM: begin
                res = alu_calc(f3, f7, a,
                    (f3 == rvirq_pkg::F3_SLL || f3 == rvirq_pkg::F3_SR) ?
                    {27'd0, imm_i[4:0]} : imm_i, 1'b0);
                if (res[32]) reg_write(rd, res[31:0]);
            end
            rvirq_pkg::OP_LOAD: begin
                addr = a + imm_i;
                case (f3)
                    rvirq_pkg::F3_LB: begin
                        v = mem_read(addr, 1);
                        reg_write(rd, {{24{v[7]}}, v[7:0]});
                    end
                    rvirq_pkg::F3_LH: begin
                        v = mem_read(addr, 2);
                        reg_write(rd, {{16{v[15]}}, v[15:0]});
                    end
                    rvirq_pkg::F3_LW:  reg_write(rd, mem_read(addr, 4));
                    rvirq_pkg::F3_LBU: reg_write(rd, mem_read(addr, 1));
                    rvirq_pkg::F3_LHU: reg_write(rd, mem_read(addr, 2));
                    default: ;
                endcase
            end
            rvirq_pkg::OP_STORE: begin
                addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                if (f3 == 3'd0) mem_write(addr, 1, b);
                else if (f3 == 3'd1) mem_write(addr, 2, b);
                else if (f3 == 3'd2) mem_write(addr, 4, b);
            end
            rvirq_pkg::OP_LUI:   reg_write(rd, ins & rvirq_pkg::UPPER_MASK);
            rvirq_pkg::OP_AUIPC: reg_write(rd, pc + (ins & rvirq_pkg::UPPER_MASK));
            rvirq_pkg::OP_JAL: begin
                nxt = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                reg_write(rd, pc + 32'd4);
            end
            rvirq_pkg::OP_JALR: begin
                nxt = (a + imm_i) & ~32'd1;
                reg_write(rd, pc + 32'd4);
            end
            rvirq_pkg::OP_BRANCH: begin
                case (f3)
                    rvirq_pkg::F3_BEQ:  take = a == b;
                    rvirq_pkg::F3_BNE:  take = a != b;
                    rvirq_pkg::F3_BLT:  take = $signed(a) < $signed(b);
                    rvirq_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
                    rvirq_pkg::F3_BLTU: take = a < b;
                    rvirq_pkg::F3_BGEU: take = a >= b;
                    default:            take = 1'b0;
                endcase
                if (take)
                    nxt = pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            end
            rvirq_pkg::OP_SYSTEM: begin
                if (ins == rvirq_pkg::INS_ECALL) begin
                    m_halt = 1'b1;
                    nxt = pc;
                end else if (ins == rvirq_pkg::INS_URET) begin
                    m_active = '0;
                    nxt = m_ret;
                end else if (ins == rvirq_pkg::INS_WFI) begin
                    m_wfi = 1'b1;
                end
            end
            default: begin
                m_halt = 1'b1;
                nxt = pc;
            end
        endcase
        m_pc = nxt;
    endtask

    task automatic core_step(logic [31:0] ins, logic [31:0] irq, output t_core_view r);
        int n;
        if (!m_halt) begin
            if (m_wfi) m_wait++;
            else m_run++;
            if (irq != 32'd0 && m_active == 32'd0) begin
                n = 0;
                while (!irq[n]) n++;
                m_wfi = 1'b0;
                m_active = 32'd1 << n;
                m_ret = m_pc;
                m_pc = 32'(4 + 4 * n);
            end else if (!m_wfi) begin
                exec_word(ins);
            end
        end
        r = '{m_pc, m_halt, m_wfi, m_active, m_run, m_wait};
    endtask

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], rvirq_pkg::OP_STORE};
    endfunction

    // queue one word; turn loads of unwritten bytes into stores
    task automatic push_word(logic [31:0] ins, logic [31:0] irq);
        t_core_view  r;
        logic [31:0] addr, ai;
        bit          safe;
        if (!m_halt && !m_wfi && !(irq != 32'd0 && m_active == 32'd0) &&
            ins[6:0] == rvirq_pkg::OP_LOAD) begin
            addr = m_rf[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            safe = 1'b1;
            for (int i = 0; i < load_size(ins[14:12]); i++) begin
                ai = addr + 32'(i);
                if (ai < MEM_BYTES && !m_written[ai]) safe = 1'b0;
            end
            if (!safe) begin
                ins[6:0] = rvirq_pkg::OP_STORE;
                ins[14] = 1'b0;
            end
        end
        core_step(ins, irq, r);
        pending_words.push_back('{ins, irq});
        expected_views.push_back(r);
    endtask

    function automatic logic [31:0] pick_irq();
        int k;
        k = $urandom_range(0, 99);
        if (m_wfi ? k >= 30 : k >= 5) return 32'd0;
        if ($urandom_range(0, 1)) return 32'd1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    task automatic gen_random();
        logic [6:0]  known_ops[10];
        logic [31:0] w;
        logic [6:0]  f7;
        logic [4:0]  base_reg;
        int          k;
        known_ops = '{rvirq_pkg::OP_REG, rvirq_pkg::OP_IMM, rvirq_pkg::OP_LOAD,
                      rvirq_pkg::OP_STORE, rvirq_pkg::OP_BRANCH, rvirq_pkg::OP_JAL,
                      rvirq_pkg::OP_JALR, rvirq_pkg::OP_LUI, rvirq_pkg::OP_AUIPC,
                      rvirq_pkg::OP_SYSTEM};
        k = $urandom_range(0, 99);
        w = $urandom;
        if (m_active != 32'd0 && $urandom_range(0, 7) == 0) begin
            w = rvirq_pkg::INS_URET;
        end else if (k < 22) begin
            f7 = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                 ($urandom_range(0, 1) ? rvirq_pkg::F7_ALT : rvirq_pkg::F7_BASE);
            w = {f7, w[24:7], rvirq_pkg::OP_REG};
        end else if (k < 40) begin
            w[6:0] = rvirq_pkg::OP_IMM;
            if (w[14:12] == rvirq_pkg::F3_SR && $urandom_range(0, 3) != 0)
                w[31:25] = $urandom_range(0, 1) ? rvirq_pkg::F7_ALT : rvirq_pkg::F7_BASE;
        end else if (k < 58) begin
            base_reg = 5'($urandom_range(1, 31));
            push_word(enc_i(12'($urandom), 5'd0, rvirq_pkg::F3_ADD, base_reg,
                            rvirq_pkg::OP_IMM), pick_irq());
            if ($urandom_range(0, 1))
                w = enc_i(w[31:20], base_reg, w[14:12], w[11:7], rvirq_pkg::OP_LOAD);
            else
                w = enc_s(w[31:20], w[24:20], base_reg, 3'($urandom_range(0, 3)));
        end else if (k < 63) begin
            w[6:0] = $urandom_range(0, 1) ? rvirq_pkg::OP_LUI : rvirq_pkg::OP_AUIPC;
        end else if (k < 73) begin
            w[6:0] = rvirq_pkg::OP_BRANCH;
        end else if (k < 78) begin
            w[6:0] = $urandom_range(0, 1) ? rvirq_pkg::OP_JAL : rvirq_pkg::OP_JALR;
        end else if (k < 84) begin
            case ($urandom_range(0, 2))
                0: w = rvirq_pkg::INS_URET;
                1: w = rvirq_pkg::INS_WFI;
                default: w[6:0] = rvirq_pkg::OP_SYSTEM;
            endcase
        end else begin
            w[6:0] = known_ops[$urandom_range(0, 9)];
        end
        if (w == rvirq_pkg::INS_ECALL || (w == rvirq_pkg::INS_WFI && m_active != 32'd0))
            w = enc_i(12'd0, 5'd0, rvirq_pkg::F3_ADD, 5'd0, rvirq_pkg::OP_IMM);
        push_word(w, pick_irq());
    endtask

    task automatic gen_directed();
        push_word(enc_i(12'hFFF, 5'd0, rvirq_pkg::F3_ADD, 5'd1, rvirq_pkg::OP_IMM), 32'd0);
        push_word({20'h80000, 5'd2, rvirq_pkg::OP_LUI}, 32'd0);
        push_word(enc_r(rvirq_pkg::F7_BASE, 5'd2, 5'd1, rvirq_pkg::F3_ADD, 5'd3,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_r(rvirq_pkg::F7_ALT, 5'd1, 5'd2, rvirq_pkg::F3_ADD, 5'd4,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_r(rvirq_pkg::F7_BASE, 5'd1, 5'd1, rvirq_pkg::F3_SLL, 5'd5,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_r(rvirq_pkg::F7_BASE, 5'd1, 5'd2, rvirq_pkg::F3_SLT, 5'd6,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_r(rvirq_pkg::F7_BASE, 5'd1, 5'd2, rvirq_pkg::F3_SLTU, 5'd7,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_r(rvirq_pkg::F7_ALT, 5'd1, 5'd2, rvirq_pkg::F3_SR, 5'd8,
                        rvirq_pkg::OP_REG), 32'd0);
        push_word(enc_i({rvirq_pkg::F7_BASE, 5'd31}, 5'd2, rvirq_pkg::F3_SR, 5'd9,
                        rvirq_pkg::OP_IMM), 32'd0);
        push_word(enc_i(12'h800, 5'd1, rvirq_pkg::F3_SLT, 5'd10, rvirq_pkg::OP_IMM), 32'd0);
        push_word(enc_s(12'd0, 5'd1, 5'd0, 3'd2), 32'd0);
        push_word(enc_i(12'd1, 5'd0, rvirq_pkg::F3_LH, 5'd11, rvirq_pkg::OP_LOAD), 32'd0);
        push_word(enc_i(12'd3, 5'd0, rvirq_pkg::F3_LBU, 5'd12, rvirq_pkg::OP_LOAD), 32'd0);
        push_word(enc_i(12'h7FF, 5'd0, rvirq_pkg::F3_ADD, 5'd13, rvirq_pkg::OP_IMM), 32'd0);
        push_word(enc_s(12'h7FF, 5'd2, 5'd13, 3'd2), 32'd0);
        push_word(enc_i(12'h7FF, 5'd13, rvirq_pkg::F3_LW, 5'd14, rvirq_pkg::OP_LOAD), 32'd0);
        push_word(enc_s(12'hFFC, 5'd1, 5'd0, 3'd2), 32'd0);
        push_word(enc_i(12'hFFC, 5'd0, rvirq_pkg::F3_LW, 5'd15, rvirq_pkg::OP_LOAD), 32'd0);
        push_word({1'b1, 6'h3F, 5'd1, 5'd1, rvirq_pkg::F3_BEQ, 4'hF, 1'b1,
                   rvirq_pkg::OP_BRANCH}, 32'd0);
        push_word({20'hFFFFF, 5'd1, rvirq_pkg::OP_JAL}, 32'd0);
        push_word(enc_i(12'h7FF, 5'd13, 3'd0, 5'd16, rvirq_pkg::OP_JALR), 32'd0);
        push_word({20'hFFFFF, 5'd17, rvirq_pkg::OP_AUIPC}, 32'd0);
        push_word(rvirq_pkg::INS_WFI, 32'd0);
        push_word(32'd0, 32'd0);
        push_word(32'd0, 32'h8000_0000);
        push_word(enc_i(12'd0, 5'd0, rvirq_pkg::F3_ADD, 5'd0, rvirq_pkg::OP_IMM),
                  32'hFFFF_FFFF);
        push_word(32'h1234_5073, 32'd0);
        push_word(rvirq_pkg::INS_URET, 32'd0);
    endtask

    task automatic report(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // drive command words
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_bus.ready) begin
            if (pending_words.size() != 0 &&
                ((cycle_no > 1500 && cycle_no < 2500) || $urandom_range(0, 99) >= 36)) begin
                cmd_bus.valid       <= 1'b1;
                cmd_bus.instruction <= pending_words[0].ins;
                cmd_bus.irq_lines   <= pending_words[0].irq;
                pending_words.pop_front();
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // result ready with random stalls and one long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (cycle_no == 600) begin
            hold_left <= 400;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= (cycle_no > 1500 && cycle_no < 2500) ||
                             $urandom_range(0, 99) >= 36;
        end
    end

    // check result words
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                report("next_pc", 64'(expected_views[0].pc), 64'(rsp_bus.next_pc));
                report("halted", 64'(expected_views[0].halted), 64'(rsp_bus.halted));
                report("waiting", 64'(expected_views[0].waiting), 64'(rsp_bus.waiting));
                report("active_irq_mask", 64'(expected_views[0].mask),
                       64'(rsp_bus.active_irq_mask));
                report("run_count", expected_views[0].run_c, rsp_bus.run_count);
                report("wait_count", expected_views[0].wait_c, rsp_bus.wait_count);
                expected_views.pop_front();
            end
        end
    end

    initial begin
        cmd_bus.valid = 1'b0;
        cmd_bus.instruction = '0;
        cmd_bus.irq_lines = '0;
        rsp_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        cycle_no = 0;
        hold_left = 0;
        foreach (m_rf[i]) m_rf[i] = '0;
        foreach (m_written[i]) m_written[i] = 1'b0;
        m_pc = '0;
        m_ret = '0;
        m_active = '0;
        m_halt = 1'b0;
        m_wfi = 1'b0;
        m_run = '0;
        m_wait = '0;
        gen_directed();
        while (pending_words.size() < N_RANDOM) gen_random();
        if (m_wfi) push_word(32'd0, 32'h0000_0001);
        push_word(rvirq_pkg::INS_ECALL, 32'd0);
        push_word(32'hFFFF_FFFF, 32'h0000_0004);
        push_word(enc_i(12'd5, 5'd0, rvirq_pkg::F3_ADD, 5'd1, rvirq_pkg::OP_IMM),
                  32'hFFFF_FFFF);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() != 0 || expected_views.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
